[rtl/pscb_pkg.sv]
`default_nettype none

package pscb_pkg;

    localparam int CoordWidth       = 32;
    localparam int MaxPointsDefault = 4096;
    localparam int InDataWidth      = 3 * CoordWidth;
    localparam int OutDataWidth     = 10 * 32;
    localparam int CfgIdxWidth      = 2;
    localparam int CfgDataWidth     = 32;

    // register indexes
    localparam logic [CfgIdxWidth-1:0] CfgScale    = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CfgRecenter = 2'd1;

    localparam logic [CfgDataWidth-1:0] ScaleReset = 32'h0001_0000;

    // axis codes
    localparam logic [1:0] AxisX = 2'd0;
    localparam logic [1:0] AxisY = 2'd1;
    localparam logic [1:0] AxisZ = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FLUSH,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_OFFSET,
        ST_PASS_INIT,
        ST_PASS,
        ST_DRAIN,
        ST_SQRT_START,
        ST_SQRT_WAIT,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic       cent_clear;
        logic       div_start;
        logic       cent_load;
        logic [1:0] axis;
        logic       offset_update;
        logic       pass_init;
        logic       pass_read;
        logic       sqrt_start;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic recenter;
        logic div_done;
        logic pass_last;
        logic pipe_busy;
        logic sqrt_done;
        logic out_busy;
    } t_status;

endpackage

`default_nettype wire

[rtl/point_set_centroid_bounds_top.sv]
`default_nettype none

// Point set centroid and bounding box.
// Input beats on s_axis carry one point each (tlast on the final point of a set).
// Each coordinate is scaled by the Q16.16 scale register and saturated, then
// stored; up to MAX_POINTS points a set, further points are dropped.
// Loading accepts one point per cycle. After the last beat input closes while:
//   a flush step; when recentring is on, the centroid division of the three
//   axes (SumW-bit sums, SumW = 32 + clog2(MAX_POINTS+1), 45 by default)
//   and an offset step; a pass reading the point memory; the square root;
//   then the summary beat is loaded into the output register.
// The memory pass over all points and the one-bit-a-cycle divider and root unit
// set the cost of a set. m_axis holds one summary beat; a stalled receiver
// holds it and input reopens at once, but the next set's summary waits for the
// register to empty. Configuration writes are always ready; they apply to the
// next set only if made between sets, which the block does not enforce.
// Reset (synchronous, active low) empties the set, clears the running
// shift and restores scale 1.0 with recentring on.
module point_set_centroid_bounds_top
    import pscb_pkg::*;
#(
    parameter int MAX_POINTS = MaxPointsDefault
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [CfgIdxWidth-1:0]  i_cfg_index,
    input  wire logic [CfgDataWidth-1:0] i_cfg_data,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // coord_x [31:0], coord_y [63:32], coord_z [95:64]
    input  wire logic [InDataWidth-1:0]  s_axis_tdata,
    input  wire logic                    s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, max_radius,
    // shift_x, shift_y, shift_z; 32 bits each from bit 0 up
    output logic [OutDataWidth-1:0]      m_axis_tdata
);

    t_cmd    w_cmd;
    t_status w_status;
    logic    w_s_accept;

    assign o_cfg_ready = 1'b1;
    assign w_s_accept  = s_axis_tvalid && s_axis_tready;

    pscb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tlast  (s_axis_tlast),
        .o_s_tready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    pscb_datapath #(
        .MAX_POINTS  (MAX_POINTS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_accept  (w_s_accept),
        .i_s_tdata   (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

`default_nettype wire

[rtl/pscb_divider.sv]
`default_nettype none

// Signed dividend by unsigned divisor, restoring, one quotient bit a cycle.
// Quotient truncates toward zero.
module pscb_divider
    import pscb_pkg::*;
#(
    parameter int DIVIDEND_W = 45,
    parameter int DIVISOR_W  = 13
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic signed [DIVIDEND_W-1:0] i_dividend,
    input  wire logic        [DIVISOR_W-1:0]  i_divisor,
    output logic                              o_done,
    output logic signed      [DIVIDEND_W-1:0] o_quot
);

    localparam int CntW = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CntW-1:0] CntLast = CntW'(DIVIDEND_W - 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CntW-1:0]       r_cnt;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_divisor;
    logic [DIVIDEND_W-1:0] r_quo;
    logic                  r_neg;

    logic [DIVISOR_W:0]    n_shift;
    logic [DIVISOR_W:0]    n_diff;
    logic                  n_bit;
    logic [DIVISOR_W-1:0]  n_rem;
    logic [DIVIDEND_W-1:0] n_mag;

    always_comb begin
        n_mag   = i_dividend[DIVIDEND_W-1] ? (DIVIDEND_W'(0) - i_dividend) : i_dividend;
        n_shift = {r_rem, r_quo[DIVIDEND_W-1]};
        n_diff  = n_shift - {1'b0, r_divisor};
        n_bit   = (n_shift >= {1'b0, r_divisor});
        n_rem   = n_bit ? n_diff[DIVISOR_W-1:0] : n_shift[DIVISOR_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt     <= CntLast;
            r_rem     <= '0;
            r_divisor <= i_divisor;
            r_quo     <= n_mag;
            r_neg     <= i_dividend[DIVIDEND_W-1];
        end else if (r_busy) begin
            r_cnt <= r_cnt - CntW'(1);
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVIDEND_W-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? $signed(DIVIDEND_W'(0) - r_quo) : $signed(r_quo);

endmodule

`default_nettype wire

[rtl/pscb_sqrt.sv]
`default_nettype none

// Integer square root, floor, one result bit a cycle.
module pscb_sqrt
    import pscb_pkg::*;
#(
    parameter int IN_W = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [IN_W-1:0]   i_value,
    output logic                   o_done,
    output logic [IN_W/2-1:0]      o_root
);

    localparam int RootW = IN_W / 2;
    localparam int RemW  = RootW + 2;
    localparam int ShW   = RemW + 2;
    localparam int CntW  = (RootW > 1) ? $clog2(RootW) : 1;
    localparam logic [CntW-1:0] CntLast = CntW'(RootW - 1);

    logic             r_busy;
    logic             r_done;
    logic [CntW-1:0]  r_cnt;
    logic [IN_W-1:0]  r_val;
    logic [RemW-1:0]  r_rem;
    logic [RootW-1:0] r_root;

    logic [ShW-1:0]   n_shift;
    logic [ShW-1:0]   n_trial;
    logic [ShW-1:0]   n_diff;
    logic             n_bit;

    always_comb begin
        n_shift = {r_rem, r_val[IN_W-1:IN_W-2]};
        n_trial = ShW'({r_root, 2'b01});
        n_diff  = n_shift - n_trial;
        n_bit   = (n_shift >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= CntLast;
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - CntW'(1);
            r_val  <= {r_val[IN_W-3:0], 2'b00};
            r_rem  <= n_bit ? n_diff[RemW-1:0] : n_shift[RemW-1:0];
            r_root <= {r_root[RootW-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

[rtl/pscb_ctrl.sv]
`default_nettype none

module pscb_ctrl
    import pscb_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    input  wire logic    i_s_tlast,
    output logic         o_s_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_axis  <= AxisX;
        end else begin
            r_state <= n_state;
            r_axis  <= n_axis;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_axis  = r_axis;
        case (r_state)
            ST_LOAD: begin
                if (i_s_tvalid && i_s_tlast) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_axis  = AxisX;
                n_state = i_status.recenter ? ST_DIV_START : ST_PASS_INIT;
            end
            ST_DIV_START: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (i_status.div_done) begin
                    if (r_axis == AxisZ) begin
                        n_state = ST_OFFSET;
                    end else begin
                        n_axis  = r_axis + 2'd1;
                        n_state = ST_DIV_START;
                    end
                end
            end
            ST_OFFSET: begin
                n_state = ST_PASS_INIT;
            end
            ST_PASS_INIT: begin
                n_state = ST_PASS;
            end
            ST_PASS: begin
                if (i_status.pass_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    n_state = ST_SQRT_START;
                end
            end
            ST_SQRT_START: begin
                n_state = ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
                if (i_status.sqrt_done) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!i_status.out_busy) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_s_tready = 1'b0;
        case (r_state)
            ST_LOAD:       o_s_tready          = 1'b1;
            ST_FLUSH:      o_cmd.cent_clear    = 1'b1;
            ST_DIV_START:  o_cmd.div_start     = 1'b1;
            ST_DIV_WAIT:   o_cmd.cent_load     = i_status.div_done;
            ST_OFFSET:     o_cmd.offset_update = 1'b1;
            ST_PASS_INIT:  o_cmd.pass_init     = 1'b1;
            ST_PASS:       o_cmd.pass_read     = 1'b1;
            ST_SQRT_START: o_cmd.sqrt_start    = 1'b1;
            ST_RESULT:     o_cmd.out_load      = !i_status.out_busy;
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_last_closes_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && i_s_tvalid && i_s_tlast) |=> !o_s_tready)
        else $error("input still open after last beat");

    a_sqrt_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.sqrt_start |-> !i_status.pipe_busy)
        else $error("root started before measurement pipe drained");

    a_div_only_recenter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.div_start |-> i_status.recenter)
        else $error("division started with recentring off");
`endif

endmodule

`default_nettype wire

[rtl/pscb_datapath.sv]
`default_nettype none

module pscb_datapath
    import pscb_pkg::*;
#(
    parameter int MAX_POINTS = MaxPointsDefault
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    input  wire logic [CfgIdxWidth-1:0]  i_cfg_index,
    input  wire logic [CfgDataWidth-1:0] i_cfg_data,
    input  wire logic                    i_s_accept,
    input  wire logic [InDataWidth-1:0]  i_s_tdata,
    input  wire t_cmd                    i_cmd,
    output t_status                      o_status,
    output logic                         o_m_tvalid,
    input  wire logic                    i_m_tready,
    output logic [OutDataWidth-1:0]      o_m_tdata
);

    localparam int CW    = CoordWidth;
    localparam int CntW  = $clog2(MAX_POINTS + 1);
    localparam int AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int SumW  = CW + CntW;
    localparam int ProdW = 2 * CW + 1;
    localparam int SqW   = 2 * CW;
    localparam logic [CntW-1:0] CntMax = CntW'(MAX_POINTS);
    localparam logic signed [CW-1:0] CoordMax = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] CoordMin = {1'b1, {(CW - 1){1'b0}}};

    function automatic logic signed [CW-1:0] sat_wide(input logic signed [ProdW-1:0] v);
        logic [ProdW-CW:0] top;
        top = v[ProdW-1:CW-1];
        if ((&top) || (~|top)) begin
            sat_wide = v[CW-1:0];
        end else begin
            sat_wide = v[ProdW-1] ? CoordMin : CoordMax;
        end
    endfunction

    function automatic logic signed [CW-1:0] sat_one(input logic signed [CW:0] v);
        if (v[CW] != v[CW-1]) begin
            sat_one = v[CW] ? CoordMin : CoordMax;
        end else begin
            sat_one = v[CW-1:0];
        end
    endfunction

    // configuration
    logic [CfgDataWidth-1:0] r_scale;
    logic                    r_recenter;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale    <= ScaleReset;
            r_recenter <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CfgScale:    r_scale    <= i_cfg_data;
                CfgRecenter: r_recenter <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // load stage: scale products, then saturate, store and sum
    logic signed [ProdW-1:0] r_prod [3];
    logic                    r_ld_valid;
    logic signed [CW-1:0]    n_coord [3];
    logic signed [CW:0]      n_scale;
    logic signed [ProdW-1:0] n_shr [3];
    logic signed [CW-1:0]    n_pt [3];
    logic                    n_room;
    logic                    n_store;

    always_comb begin
        n_scale = $signed({1'b0, r_scale});
        for (int a = 0; a < 3; a++) begin
            n_coord[a] = $signed(i_s_tdata[a*CW +: CW]);
            n_shr[a]   = r_prod[a] >>> 16;
            n_pt[a]    = sat_wide(n_shr[a]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_valid <= 1'b0;
        end else begin
            r_ld_valid <= i_s_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_accept) begin
            for (int a = 0; a < 3; a++) begin
                r_prod[a] <= n_coord[a] * n_scale;
            end
        end
    end

    logic [CntW-1:0]       r_count;
    logic signed [SumW-1:0] r_sum [3];

    assign n_room  = (r_count < CntMax);
    assign n_store = r_ld_valid && n_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
            end
        end else if (i_cmd.out_load) begin
            r_count <= '0;
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= '0;
            end
        end else if (n_store) begin
            r_count <= r_count + CntW'(1);
            for (int a = 0; a < 3; a++) begin
                r_sum[a] <= r_sum[a] + {{(SumW - CW){n_pt[a][CW-1]}}, n_pt[a]};
            end
        end
    end

    // point memory
    logic [3*CW-1:0]  r_mem [MAX_POINTS];
    logic [3*CW-1:0]  r_rd_data;
    logic [AddrW-1:0] r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (n_store) begin
            r_mem[r_count[AddrW-1:0]] <= {n_pt[2], n_pt[1], n_pt[0]};
        end
        if (i_cmd.pass_read) begin
            r_rd_data <= r_mem[r_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pass_init) begin
            r_rd_addr <= '0;
        end else if (i_cmd.pass_read) begin
            r_rd_addr <= r_rd_addr + AddrW'(1);
        end
    end

    // centroid, one shared divider over the three axes
    logic signed [SumW-1:0] n_dividend;
    logic                   w_div_done;
    logic signed [SumW-1:0] w_quot;
    logic signed [CW-1:0]   r_cent [3];

    always_comb begin
        case (i_cmd.axis)
            AxisX:   n_dividend = r_sum[0];
            AxisY:   n_dividend = r_sum[1];
            default: n_dividend = r_sum[2];
        endcase
    end

    pscb_divider #(
        .DIVIDEND_W (SumW),
        .DIVISOR_W  (CntW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_dividend),
        .i_divisor  (r_count),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.cent_clear) begin
            for (int a = 0; a < 3; a++) begin
                r_cent[a] <= '0;
            end
        end else if (i_cmd.cent_load) begin
            case (i_cmd.axis)
                AxisX:   r_cent[0] <= w_quot[CW-1:0];
                AxisY:   r_cent[1] <= w_quot[CW-1:0];
                default: r_cent[2] <= w_quot[CW-1:0];
            endcase
        end
    end

    // running offset, kept across sets
    logic signed [CW-1:0] r_offset [3];
    logic signed [CW-1:0] n_negc [3];
    logic signed [CW-1:0] n_offset [3];

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_negc[a]   = sat_one((CW + 1)'(0) - {r_cent[a][CW-1], r_cent[a]});
            n_offset[a] = sat_one({r_offset[a][CW-1], r_offset[a]}
                                  + {n_negc[a][CW-1], n_negc[a]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < 3; a++) begin
                r_offset[a] <= '0;
            end
        end else if (i_cmd.offset_update) begin
            for (int a = 0; a < 3; a++) begin
                r_offset[a] <= n_offset[a];
            end
        end
    end

    // measurement pipe: translate, bounds and squares, radius squared
    logic                 r_p1, r_p2, r_p3;
    logic signed [CW-1:0] r_v [3];
    logic signed [CW-1:0] n_v [3];
    logic signed [CW-1:0] r_lo [3];
    logic signed [CW-1:0] r_hi [3];
    logic [CW-1:0]        n_mag [3];
    logic [SqW-1:0]       r_sq [3];
    logic [SqW+1:0]       n_r2;
    logic [SqW-1:0]       r_best2;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            n_v[a]   = sat_one({r_rd_data[a*CW+CW-1], r_rd_data[a*CW +: CW]}
                               - {r_cent[a][CW-1], r_cent[a]});
            n_mag[a] = r_v[a][CW-1] ? (CW'(0) - r_v[a]) : r_v[a];
        end
        n_r2 = (SqW + 2)'(r_sq[0]) + (SqW + 2)'(r_sq[1]) + (SqW + 2)'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1 <= 1'b0;
            r_p2 <= 1'b0;
            r_p3 <= 1'b0;
        end else begin
            r_p1 <= i_cmd.pass_read;
            r_p2 <= r_p1;
            r_p3 <= r_p2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_p1) begin
            for (int a = 0; a < 3; a++) begin
                r_v[a] <= n_v[a];
            end
        end
        if (r_p2) begin
            for (int a = 0; a < 3; a++) begin
                r_sq[a] <= n_mag[a] * n_mag[a];
            end
        end
        if (i_cmd.pass_init) begin
            for (int a = 0; a < 3; a++) begin
                r_lo[a] <= CoordMax;
                r_hi[a] <= CoordMin;
            end
            r_best2 <= '0;
        end else begin
            if (r_p2) begin
                for (int a = 0; a < 3; a++) begin
                    if (r_v[a] < r_lo[a]) r_lo[a] <= r_v[a];
                    if (r_v[a] > r_hi[a]) r_hi[a] <= r_v[a];
                end
            end
            // three squares of 32-bit magnitudes stay below 2^64
            if (r_p3 && (n_r2[SqW-1:0] > r_best2)) begin
                r_best2 <= n_r2[SqW-1:0];
            end
        end
    end

    // radius
    logic          w_sqrt_done;
    logic [CW-1:0] w_root;

    pscb_sqrt #(
        .IN_W    (SqW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.sqrt_start),
        .i_value (r_best2),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    // output register
    logic                    r_out_valid;
    logic [OutDataWidth-1:0] r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {r_offset[2], r_offset[1], r_offset[0], w_root,
                           r_hi[2], r_hi[1], r_hi[0], r_lo[2], r_lo[1], r_lo[0]};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    always_comb begin
        o_status.recenter  = r_recenter;
        o_status.div_done  = w_div_done;
        o_status.pass_last = (CntW'(r_rd_addr) == (r_count - CntW'(1)));
        o_status.pipe_busy = r_p1 || r_p2 || r_p3;
        o_status.sqrt_done = w_sqrt_done;
        o_status.out_busy  = r_out_valid && !i_m_tready;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntMax)
        else $error("point count beyond store depth");

    a_read_in_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pass_read |-> (CntW'(r_rd_addr) < r_count))
        else $error("pass reads beyond the stored points");

    a_no_load_in_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pass_read || r_p1 || r_p2 || r_p3) |-> !r_ld_valid)
        else $error("point loaded while the store is being measured");
`endif

endmodule

`default_nettype wire
